### sv/spiem_pkg.sv
// Shared types and constants of the SPI EEPROM command master.
package spiem_pkg;

  localparam int unsigned ADDR_WIDTH = 24;
  localparam int unsigned ADDR_BYTES = (ADDR_WIDTH + 7) / 8;
  localparam int unsigned ADDR_HDR_W = 8 * ADDR_BYTES;
  // Opcode, address bytes and one data byte.
  localparam int unsigned SH_W = 8 * (ADDR_BYTES + 2);
  localparam int unsigned CNT_W = $clog2(SH_W + 1);

  localparam logic [7:0] OP_READ = 8'h03;
  localparam logic [7:0] OP_WRITE = 8'h02;
  localparam logic [7:0] OP_RDSR = 8'h05;

  localparam logic [10:0] READ_LIMIT_RST = 11'd1024;
  localparam logic [8:0] WRITE_LIMIT_RST = 9'd256;

  localparam logic REG_READ_LIMIT = 1'b0;
  localparam logic REG_WRITE_LIMIT = 1'b1;

  typedef logic [ADDR_HDR_W-1:0] addr_ext_t;
  typedef logic [CNT_W-1:0] bit_cnt_t;

  typedef enum logic [2:0] {
    ACT_SINGLE  = 3'd0,
    ACT_RDSR    = 3'd1,
    ACT_OPEN_RD = 3'd2,
    ACT_OPEN_WR = 3'd3,
    ACT_DATA    = 3'd4,
    ACT_CLOSE   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DROP = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_READ  = 3'b010,
    MODE_WRITE = 3'b100
  } mode_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [23:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  miso_byte;
  } in_item_t;

  typedef struct packed {
    logic       cs_active;
    logic       clock_pulse;
    logic       mosi_bit;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // One classified item: either a single plain result, or a run of clock
  // bits (shifted out MSB first, the final byte received when recv is set),
  // optionally followed by a chip-select release.
  typedef struct packed {
    logic            plain;
    logic            plain_cs;
    status_e         status;
    logic            rel;
    logic            recv;
    bit_cnt_t        nbits;
    logic [SH_W-1:0] sh;
    logic [7:0]      miso;
  } job_t;

endpackage

### sv/spi_eeprom_command_master.sv
// Top level of the SPI EEPROM command master: front end, item queue, back end.
// An item passes a queue entry and the back end's job register; results are registered.
// One result per cycle unless the receiver stalls; a data byte yields 8 results, the first
// data byte of a transaction 8*(ADDR_BYTES+2) = 40, single command 9, status read 17, others 1.
// Items keep arriving while the back end serializes, until the two-entry queue fills.
// Reset (async, active low) idles the transaction state and sets the limits to 1024/256.
module spi_eeprom_command_master (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  spiem_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output spiem_pkg::out_item_t out_item_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [10:0]          cfg_data_i
);

  logic            push_valid, push_ready;
  spiem_pkg::job_t push_job;
  logic            pop_valid, pop_ready;
  spiem_pkg::job_t pop_job;

  spiem_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .job_valid_o (push_valid),
    .job_o       (push_job),
    .job_ready_i (push_ready)
  );

  spiem_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_i       (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_o        (pop_job)
  );

  spiem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

### sv/spiem_front.sv
// Front end: accepts items, keeps the transaction state and classifies each item.
module spiem_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spiem_pkg::in_item_t in_item_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [10:0]         cfg_data_i,
  output logic                job_valid_o,
  output spiem_pkg::job_t     job_o,
  input  logic                job_ready_i
);

  spiem_pkg::mode_e                mode_q, mode_d;
  logic [spiem_pkg::ADDR_WIDTH-1:0] addr_q, addr_d;
  logic                             hdr_sent_q, hdr_sent_d;
  logic [10:0]                      byte_cnt_q, byte_cnt_d;
  logic [10:0]                      read_limit_q;
  logic [8:0]                       write_limit_q;
  logic                             accept;

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign accept      = in_valid_i & job_ready_i;

  always_comb begin
    logic [10:0] lim;
    mode_d     = mode_q;
    addr_d     = addr_q;
    hdr_sent_d = hdr_sent_q;
    byte_cnt_d = byte_cnt_q;
    lim        = (mode_q == spiem_pkg::MODE_READ) ? read_limit_q
                                                   : {2'b00, write_limit_q};

    job_o          = '0;
    job_o.plain    = 1'b1;
    job_o.plain_cs = (mode_q != spiem_pkg::MODE_IDLE) && hdr_sent_q;
    job_o.status   = spiem_pkg::ST_BAD;
    job_o.miso     = in_item_i.miso_byte;

    case (spiem_pkg::action_e'(in_item_i.action))
      spiem_pkg::ACT_SINGLE: begin
        if (mode_q == spiem_pkg::MODE_IDLE) begin
          job_o.plain                      = 1'b0;
          job_o.status                     = spiem_pkg::ST_OK;
          job_o.rel                        = 1'b1;
          job_o.nbits                      = spiem_pkg::bit_cnt_t'(8);
          job_o.sh[spiem_pkg::SH_W-1 -: 8] = in_item_i.data_byte;
        end
      end
      spiem_pkg::ACT_RDSR: begin
        if (mode_q == spiem_pkg::MODE_IDLE) begin
          job_o.plain                      = 1'b0;
          job_o.status                     = spiem_pkg::ST_OK;
          job_o.rel                        = 1'b1;
          job_o.recv                       = 1'b1;
          job_o.nbits                      = spiem_pkg::bit_cnt_t'(16);
          job_o.sh[spiem_pkg::SH_W-1 -: 8] = spiem_pkg::OP_RDSR;
        end
      end
      spiem_pkg::ACT_OPEN_RD, spiem_pkg::ACT_OPEN_WR: begin
        if (mode_q == spiem_pkg::MODE_IDLE) begin
          job_o.status = spiem_pkg::ST_OK;
          mode_d       = (in_item_i.action == spiem_pkg::ACT_OPEN_RD) ?
                         spiem_pkg::MODE_READ : spiem_pkg::MODE_WRITE;
          addr_d       = in_item_i.address[spiem_pkg::ADDR_WIDTH-1:0];
          hdr_sent_d   = 1'b0;
          byte_cnt_d   = '0;
        end
      end
      spiem_pkg::ACT_DATA: begin
        if (mode_q != spiem_pkg::MODE_IDLE) begin
          if (byte_cnt_q >= lim) begin
            job_o.status = spiem_pkg::ST_DROP;
          end else begin
            job_o.plain  = 1'b0;
            job_o.status = spiem_pkg::ST_OK;
            job_o.recv   = (mode_q == spiem_pkg::MODE_READ);
            if (!hdr_sent_q) begin
              // Opcode and address go out ahead of the first data byte.
              job_o.nbits = spiem_pkg::bit_cnt_t'(spiem_pkg::SH_W);
              job_o.sh    = {(mode_q == spiem_pkg::MODE_READ) ? spiem_pkg::OP_READ
                                                              : spiem_pkg::OP_WRITE,
                             spiem_pkg::addr_ext_t'(addr_q),
                             in_item_i.data_byte};
            end else begin
              job_o.nbits                      = spiem_pkg::bit_cnt_t'(8);
              job_o.sh[spiem_pkg::SH_W-1 -: 8] = in_item_i.data_byte;
            end
            hdr_sent_d = 1'b1;
            byte_cnt_d = byte_cnt_q + 11'd1;
          end
        end
      end
      spiem_pkg::ACT_CLOSE: begin
        if (mode_q != spiem_pkg::MODE_IDLE) begin
          job_o.plain  = 1'b0;
          job_o.status = spiem_pkg::ST_OK;
          job_o.rel    = 1'b1;
          mode_d       = spiem_pkg::MODE_IDLE;
          hdr_sent_d   = 1'b0;
          byte_cnt_d   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= spiem_pkg::MODE_IDLE;
      addr_q     <= '0;
      hdr_sent_q <= 1'b0;
      byte_cnt_q <= '0;
    end else if (accept) begin
      mode_q     <= mode_d;
      addr_q     <= addr_d;
      hdr_sent_q <= hdr_sent_d;
      byte_cnt_q <= byte_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_limit_q  <= spiem_pkg::READ_LIMIT_RST;
      write_limit_q <= spiem_pkg::WRITE_LIMIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == spiem_pkg::REG_READ_LIMIT) begin
        read_limit_q <= cfg_data_i;
      end
      if (cfg_idx_i == spiem_pkg::REG_WRITE_LIMIT) begin
        write_limit_q <= cfg_data_i[8:0];
      end
    end
  end

endmodule

### sv/spiem_queue.sv
// Two-entry queue of classified items between the front and back ends.
module spiem_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  spiem_pkg::job_t push_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output spiem_pkg::job_t pop_o
);

  spiem_pkg::job_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_o        = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_matches_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue count disagrees with pointers");

endmodule

### sv/spiem_back.sv
// Back end: plays each classified item out as serial bit results.
module spiem_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  spiem_pkg::job_t      job_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output spiem_pkg::out_item_t out_item_o
);

  logic                       busy_q;
  spiem_pkg::job_t            job_q;
  spiem_pkg::bit_cnt_t        cnt_q;
  logic [spiem_pkg::SH_W-1:0] sh_q;
  logic                       mosi_q, mosi_d;
  logic                       out_valid_q;
  spiem_pkg::out_item_t       out_q, res;
  logic                       step, done;

  assign step        = busy_q & (~out_valid_q | out_ready_i);
  assign done        = step & res.last;
  assign job_ready_o = ~busy_q | done;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    res    = '0;
    mosi_d = mosi_q;
    if (job_q.plain) begin
      res.cs_active = job_q.plain_cs;
      res.mosi_bit  = mosi_q;
      res.status    = job_q.status;
      res.last      = 1'b1;
    end else if (cnt_q != '0) begin
      res.cs_active   = 1'b1;
      res.clock_pulse = 1'b1;
      res.last        = (cnt_q == spiem_pkg::bit_cnt_t'(1)) && !job_q.rel;
      if (job_q.recv && cnt_q <= spiem_pkg::bit_cnt_t'(8)) begin
        // Serial out holds while the device drives its byte.
        res.mosi_bit = mosi_q;
        if (cnt_q == spiem_pkg::bit_cnt_t'(1)) begin
          res.rx_valid = 1'b1;
          res.rx_byte  = job_q.miso;
        end
      end else begin
        res.mosi_bit = sh_q[spiem_pkg::SH_W-1];
        mosi_d       = sh_q[spiem_pkg::SH_W-1];
      end
    end else begin
      res.last = 1'b1;
      mosi_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      job_q       <= '0;
      cnt_q       <= '0;
      sh_q        <= '0;
      mosi_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (step) begin
        out_q       <= res;
        out_valid_q <= 1'b1;
        mosi_q      <= mosi_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (job_ready_o) begin
        busy_q <= job_valid_i;
      end
      if (job_ready_o && job_valid_i) begin
        job_q <= job_i;
        cnt_q <= job_i.nbits;
        sh_q  <= job_i.sh;
      end else if (step && cnt_q != '0) begin
        cnt_q <= cnt_q - spiem_pkg::bit_cnt_t'(1);
        sh_q  <= sh_q << 1;
      end
    end
  end

  a_empty_job_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !job_q.plain && cnt_q == '0) |-> job_q.rel)
    else $error("clocked item ended without last result");

  a_rx_in_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.rx_valid) |-> (out_q.clock_pulse && out_q.cs_active))
    else $error("received byte outside a clocked bit");

  a_clock_needs_cs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.cs_active) |-> !out_q.clock_pulse)
    else $error("serial clock without chip select");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("result changed while stalled");

endmodule

### sim/spi_eeprom_command_master_tb.sv
// Self-checking testbench for the SPI EEPROM command master, bit-level prediction.
`timescale 1ns / 100ps

module spi_eeprom_command_master_tb;

  // Action codes the block must refuse.
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  // The slowest correct run is far below this: about 400 items of up to 40 bits,
  // each bit waiting out a mostly stalled receiver, plus the long hold-off.
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_AT_RESULT = 1500;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 58;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct {
    spiem_pkg::in_item_t  item;
    bit                   typed;
    spiem_pkg::out_item_t want;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  spiem_pkg::in_item_t  in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  spiem_pkg::out_item_t out_item;
  logic                 cfg_we = 1'b0;
  logic                 cfg_idx = spiem_pkg::REG_READ_LIMIT;
  logic [10:0]          cfg_data = '0;

  // Predicted bus state.
  spiem_pkg::mode_e sm_mode;
  logic [23:0]      sm_addr;
  logic             sm_hdr;
  logic [10:0]      sm_count;
  logic             sm_mosi;
  logic [10:0]      lim_rd;
  logic [8:0]       lim_wr;

  spiem_pkg::out_item_t pred_bits[$];
  spiem_pkg::out_item_t awaited_bits[$];
  stim_row_t            dir_rows[$];

  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned drops_seen = 0;
  int unsigned transfers = 0;
  int unsigned cycle_cnt = 0;
  int          burst_left = 1;
  bit          gapless = 1'b0;

  spi_eeprom_command_master u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  function automatic spiem_pkg::out_item_t bit_out(logic cs, logic sck, logic mosi,
                                                   logic [7:0] rx, logic rxv,
                                                   spiem_pkg::status_e st, logic fin);
    spiem_pkg::out_item_t o;
    o.cs_active   = cs;
    o.clock_pulse = sck;
    o.mosi_bit    = mosi;
    o.rx_byte     = rx;
    o.rx_valid    = rxv;
    o.status      = st;
    o.last        = fin;
    return o;
  endfunction

  function automatic spiem_pkg::in_item_t mk_in(logic [2:0] act, logic [23:0] addr,
                                                logic [7:0] data, logic [7:0] miso);
    spiem_pkg::in_item_t it;
    it.action    = act;
    it.address   = addr;
    it.data_byte = data;
    it.miso_byte = miso;
    return it;
  endfunction

  function automatic spiem_pkg::in_item_t rnd_in(logic [2:0] act);
    return mk_in(act, 24'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic void shift_out(logic [7:0] b);
    int i;
    for (i = 7; i >= 0; i--) begin
      sm_mosi = b[i];
      pred_bits.push_back(bit_out(1'b1, 1'b1, sm_mosi, 8'h00, 1'b0, spiem_pkg::ST_OK,
                                  1'b0));
    end
  endfunction

  function automatic void shift_in(logic [7:0] miso);
    logic [7:0] acc;
    int i;
    acc = '0;
    for (i = 7; i >= 0; i--) begin
      acc = {acc[6:0], miso[i]};
      pred_bits.push_back(bit_out(1'b1, 1'b1, sm_mosi, (i == 0) ? acc : 8'h00, i == 0,
                                  spiem_pkg::ST_OK, 1'b0));
    end
  endfunction

  function automatic void cs_release();
    sm_mosi = 1'b0;
    pred_bits.push_back(bit_out(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, spiem_pkg::ST_OK, 1'b0));
  endfunction

  // A period without a clock; chip select stays as it is.
  function automatic void idle_bit(spiem_pkg::status_e st);
    logic cs;
    cs = (sm_mode != spiem_pkg::MODE_IDLE) && sm_hdr;
    pred_bits.push_back(bit_out(cs, 1'b0, sm_mosi, 8'h00, 1'b0, st, 1'b0));
    if (st == spiem_pkg::ST_DROP) drops_seen++;
  endfunction

  function automatic void predict_item(spiem_pkg::in_item_t it);
    logic [10:0] lim;
    int k;
    pred_bits.delete();
    case (it.action)
      spiem_pkg::ACT_SINGLE: begin
        if (sm_mode != spiem_pkg::MODE_IDLE) begin
          idle_bit(spiem_pkg::ST_BAD);
        end else begin
          shift_out(it.data_byte);
          cs_release();
        end
      end
      spiem_pkg::ACT_RDSR: begin
        if (sm_mode != spiem_pkg::MODE_IDLE) begin
          idle_bit(spiem_pkg::ST_BAD);
        end else begin
          shift_out(spiem_pkg::OP_RDSR);
          shift_in(it.miso_byte);
          cs_release();
        end
      end
      spiem_pkg::ACT_OPEN_RD, spiem_pkg::ACT_OPEN_WR: begin
        if (sm_mode != spiem_pkg::MODE_IDLE) begin
          idle_bit(spiem_pkg::ST_BAD);
        end else begin
          sm_mode  = (it.action == spiem_pkg::ACT_OPEN_RD) ? spiem_pkg::MODE_READ
                                                           : spiem_pkg::MODE_WRITE;
          sm_addr  = it.address & 24'((32'd1 << spiem_pkg::ADDR_WIDTH) - 1);
          sm_hdr   = 1'b0;
          sm_count = '0;
          idle_bit(spiem_pkg::ST_OK);
        end
      end
      spiem_pkg::ACT_DATA: begin
        lim = (sm_mode == spiem_pkg::MODE_READ) ? lim_rd : 11'(lim_wr);
        if (sm_mode == spiem_pkg::MODE_IDLE) begin
          idle_bit(spiem_pkg::ST_BAD);
        end else if (sm_count >= lim) begin
          idle_bit(spiem_pkg::ST_DROP);
        end else begin
          // The opcode and address ride along with the first data byte only.
          if (!sm_hdr) begin
            shift_out((sm_mode == spiem_pkg::MODE_READ) ? spiem_pkg::OP_READ
                                                        : spiem_pkg::OP_WRITE);
            for (k = spiem_pkg::ADDR_BYTES - 1; k >= 0; k--) begin
              shift_out(8'(sm_addr >> (8 * k)));
            end
            sm_hdr = 1'b1;
          end
          if (sm_mode == spiem_pkg::MODE_READ) shift_in(it.miso_byte);
          else shift_out(it.data_byte);
          sm_count = sm_count + 1'b1;
        end
      end
      spiem_pkg::ACT_CLOSE: begin
        if (sm_mode == spiem_pkg::MODE_IDLE) begin
          idle_bit(spiem_pkg::ST_BAD);
        end else begin
          cs_release();
          sm_mode  = spiem_pkg::MODE_IDLE;
          sm_hdr   = 1'b0;
          sm_count = '0;
        end
      end
      default: idle_bit(spiem_pkg::ST_BAD);
    endcase
    pred_bits[pred_bits.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("ERROR result %0d: %s", results_seen, msg);
  endtask

  task automatic cmp_field(string name, int unsigned got, int unsigned want);
    if (got != want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic check_result(spiem_pkg::out_item_t got);
    spiem_pkg::out_item_t want;
    if (awaited_bits.size() == 0) begin
      report_mismatch($sformatf("result with nothing awaited: %p", got));
      return;
    end
    want = awaited_bits.pop_front();
    cmp_field("cs_active", got.cs_active, want.cs_active);
    cmp_field("clock_pulse", got.clock_pulse, want.clock_pulse);
    cmp_field("mosi_bit", got.mosi_bit, want.mosi_bit);
    cmp_field("rx_byte", got.rx_byte, want.rx_byte);
    cmp_field("rx_valid", got.rx_valid, want.rx_valid);
    cmp_field("status", got.status, want.status);
    cmp_field("last", got.last, want.last);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      check_result(out_item);
      results_seen++;
    end
  end

  // Receiver: random stall patterns, and one long hold-off that fills the block.
  initial begin : result_sink
    int mode;
    int left;
    bit held;
    mode = 0;
    left = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= HOLD_AT_RESULT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (left == 0) begin
        mode = $urandom_range(3);
        left = $urandom_range(10, 60);
      end
      left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(3) != 0);
        2: out_ready <= ($urandom_range(3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results still awaited", cycle_cnt,
             awaited_bits.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Offers one item, records its expected bits once it is taken, then maybe pauses.
  task automatic offer(spiem_pkg::in_item_t it, bit typed, spiem_pkg::out_item_t want);
    int gap;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    predict_item(it);
    if (typed) awaited_bits.push_back(want);
    else foreach (pred_bits[i]) awaited_bits.push_back(pred_bits[i]);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gapless ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_bits.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limits(logic [10:0] rd, logic [8:0] wr);
    cfg_we   <= 1'b1;
    cfg_idx  <= spiem_pkg::REG_READ_LIMIT;
    cfg_data <= rd;
    @(posedge clk_i);
    cfg_idx  <= spiem_pkg::REG_WRITE_LIMIT;
    cfg_data <= 11'(wr);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    lim_rd = rd;
    lim_wr = wr;
  endtask

  task automatic add_row(logic [2:0] act, logic [23:0] addr, logic [7:0] data,
                         logic [7:0] miso, bit typed, spiem_pkg::out_item_t want);
    stim_row_t r;
    r.item  = mk_in(act, addr, data, miso);
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  task automatic random_items(int unsigned n);
    int unsigned stop;
    int nb;
    int i;
    logic [2:0] open_act;
    logic [10:0] lim;
    stop = items_sent + n;
    while (items_sent < stop) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          open_act = $urandom_range(1) ? spiem_pkg::ACT_OPEN_RD : spiem_pkg::ACT_OPEN_WR;
          lim = (open_act == spiem_pkg::ACT_OPEN_RD) ? lim_rd : 11'(lim_wr);
          // Small limits get run into and past; large ones see short transfers.
          if (lim <= 8) nb = $urandom_range(0, lim + 2);
          else nb = ($urandom_range(7) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 6);
          offer(rnd_in(open_act), 1'b0, '0);
          for (i = 0; i < nb; i++) offer(rnd_in(spiem_pkg::ACT_DATA), 1'b0, '0);
          offer(rnd_in(spiem_pkg::ACT_CLOSE), 1'b0, '0);
          transfers++;
        end
        6: offer(rnd_in(spiem_pkg::ACT_SINGLE), 1'b0, '0);
        7: offer(rnd_in(spiem_pkg::ACT_RDSR), 1'b0, '0);
        8: offer(rnd_in(3'($urandom_range(7))), 1'b0, '0);
        default: begin
          // Broken sequence: an open followed by stray actions, left for later items.
          offer(rnd_in($urandom_range(1) ? spiem_pkg::ACT_OPEN_RD : spiem_pkg::ACT_OPEN_WR),
                1'b0, '0);
          offer(rnd_in(3'($urandom_range(7))), 1'b0, '0);
          if ($urandom_range(1)) offer(rnd_in(spiem_pkg::ACT_DATA), 1'b0, '0);
        end
      endcase
    end
    if (sm_mode != spiem_pkg::MODE_IDLE) offer(rnd_in(spiem_pkg::ACT_CLOSE), 1'b0, '0);
  endtask

  initial begin : stimulus
    spiem_pkg::out_item_t bad_idle;
    spiem_pkg::out_item_t rel_ok;
    int p;
    sm_mode  = spiem_pkg::MODE_IDLE;
    sm_addr  = '0;
    sm_hdr   = 1'b0;
    sm_count = '0;
    sm_mosi  = 1'b0;
    lim_rd   = spiem_pkg::READ_LIMIT_RST;
    lim_wr   = spiem_pkg::WRITE_LIMIT_RST;
    bad_idle = bit_out(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, spiem_pkg::ST_BAD, 1'b1);
    rel_ok   = bit_out(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, spiem_pkg::ST_OK, 1'b1);

    add_row(spiem_pkg::ACT_DATA, 24'h000000, 8'h00, 8'h00, 1'b1, bad_idle);
    add_row(spiem_pkg::ACT_CLOSE, 24'h000000, 8'h00, 8'h00, 1'b1, bad_idle);
    add_row(ACT_SPARE6, 24'h000000, 8'h00, 8'h00, 1'b1, bad_idle);
    add_row(ACT_SPARE7, 24'hffffff, 8'hff, 8'hff, 1'b1, bad_idle);
    add_row(spiem_pkg::ACT_SINGLE, 24'h000000, 8'hff, 8'h00, 1'b0, '0);
    add_row(spiem_pkg::ACT_SINGLE, 24'hffffff, 8'h00, 8'hff, 1'b0, '0);
    add_row(spiem_pkg::ACT_RDSR, 24'h000000, 8'h00, 8'ha5, 1'b0, '0);
    add_row(spiem_pkg::ACT_RDSR, 24'h000000, 8'h00, 8'hff, 1'b0, '0);
    add_row(spiem_pkg::ACT_OPEN_WR, 24'hffffff, 8'h00, 8'h00, 1'b1, rel_ok);
    add_row(spiem_pkg::ACT_OPEN_RD, 24'h000000, 8'h00, 8'h00, 1'b1, bad_idle);
    add_row(spiem_pkg::ACT_SINGLE, 24'h000000, 8'h55, 8'h00, 1'b1, bad_idle);
    add_row(spiem_pkg::ACT_DATA, 24'h000000, 8'hff, 8'h00, 1'b0, '0);
    add_row(spiem_pkg::ACT_DATA, 24'h000000, 8'h00, 8'h00, 1'b0, '0);
    // With chip select held, a refused item shows the last bit driven.
    add_row(spiem_pkg::ACT_OPEN_WR, 24'h000000, 8'h00, 8'h00, 1'b1,
            bit_out(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, spiem_pkg::ST_BAD, 1'b1));
    add_row(spiem_pkg::ACT_DATA, 24'h000000, 8'h81, 8'h00, 1'b0, '0);
    add_row(spiem_pkg::ACT_RDSR, 24'h000000, 8'h00, 8'h00, 1'b1,
            bit_out(1'b1, 1'b0, 1'b1, 8'h00, 1'b0, spiem_pkg::ST_BAD, 1'b1));
    add_row(spiem_pkg::ACT_CLOSE, 24'h000000, 8'h00, 8'h00, 1'b1, rel_ok);
    add_row(spiem_pkg::ACT_OPEN_RD, 24'h000000, 8'h00, 8'h00, 1'b0, '0);
    add_row(spiem_pkg::ACT_CLOSE, 24'h000000, 8'h00, 8'h00, 1'b1, rel_ok);
    add_row(spiem_pkg::ACT_OPEN_RD, 24'h5a0f3c, 8'h00, 8'h00, 1'b0, '0);
    add_row(spiem_pkg::ACT_DATA, 24'h000000, 8'h00, 8'hff, 1'b0, '0);
    add_row(spiem_pkg::ACT_DATA, 24'h000000, 8'h00, 8'h00, 1'b0, '0);
    add_row(spiem_pkg::ACT_DATA, 24'h000000, 8'hff, 8'h80, 1'b0, '0);
    add_row(spiem_pkg::ACT_CLOSE, 24'h000000, 8'h00, 8'h00, 1'b1, rel_ok);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    drain();

    for (p = 0; p < 6; p++) begin
      case (p)
        0: set_limits(11'd1, 9'd1);
        1: set_limits(spiem_pkg::READ_LIMIT_RST, spiem_pkg::WRITE_LIMIT_RST);
        2: set_limits(11'd0, 9'd0);
        3: set_limits(11'd2, 9'd5);
        default: set_limits(11'($urandom_range(1, 9)), 9'($urandom_range(1, 9)));
      endcase
      gapless = (p == 3);
      random_items(PHASE_ITEMS);
      drain();
    end

    repeat (16) @(posedge clk_i);
    $display("Covered %0d items (%0d random transfers) and %0d result bits over 7 limit settings;",
             items_sent, transfers, results_seen);
    $display("%0d bytes were dropped at the limit, %0d mismatches found.", drops_seen,
             mismatches);
    if (mismatches == 0 && awaited_bits.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
